/* hdl/zlhs_pkg.sv */
package zlhs_pkg;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_NAME   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    localparam logic [7:0] SIG_B0 = 8'h50;
    localparam logic [7:0] SIG_B1 = 8'h4B;
    localparam logic [7:0] SIG_B2 = 8'h03;
    localparam logic [7:0] SIG_B3 = 8'h04;

    localparam logic [4:0] HDR_FIRST_IDX = 5'd4;
    localparam logic [4:0] HDR_LAST_IDX  = 5'd29;
    localparam int         HDR_SR_DEPTH  = 21;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_NAME   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_CLEAN      = 2'd0;
    localparam logic [1:0] ST_TRUNC_HDR  = 2'd1;
    localparam logic [1:0] ST_TRUNC_NAME = 2'd2;
    localparam logic [1:0] ST_TRUNC_SKIP = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;
        logic [1:0]  status;
        logic [7:0]  name_byte;
        logic [15:0] extra_length;
        logic [15:0] name_length;
        logic [31:0] plain_size;
        logic [31:0] packed_size;
        logic [15:0] method;
    } result_t;

endpackage

/* hdl/zip_local_header_scanner_core.sv */
// Results are written into a four-entry result queue on the beat that causes them.
// Throughput: one input beat per cycle while s_tready is high; the final beat of an
// archive may yield two results, both written into the queue in the same cycle.
// s_tready drops while the queue has fewer than two free slots.
// Reset: synchronous, active low; clears the scanner state and empties the queue.
module zip_local_header_scanner_core
    import zlhs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // in_byte[7:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // method, packed_size, plain_size, name_length,
                                    // extra_length, name_byte, status, zero fill
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast
);

    phase_t        phase_reg, phase_next;
    logic [23:0]   win_reg, win_next;
    logic [4:0]    idx_reg, idx_next;
    logic [15:0]   name_left_reg, name_left_next;
    logic [32:0]   skip_left_reg, skip_left_next;
    logic [7:0]    hdr_sr_reg [0:HDR_SR_DEPTH-1];

    result_t       rec, stat;
    logic          rec_valid;
    logic          s_fire, m_fire;
    logic [1:0]    push_n;
    result_t       slot_a;

    result_t           fifo_mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    result_t           head;

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign s_tready = cnt_reg <= CNT_W'(FIFO_DEPTH - 2);

    always_comb begin
        phase_next     = phase_reg;
        win_next       = win_reg;
        idx_next       = idx_reg;
        name_left_next = name_left_reg;
        skip_left_next = skip_left_reg;
        rec_valid      = 1'b0;
        rec            = '0;
        stat           = '0;
        stat.kind      = KIND_STATUS;
        case (phase_reg)
            PH_HEADER: begin
                if (idx_reg >= HDR_LAST_IDX) begin
                    rec_valid        = 1'b1;
                    rec.kind         = KIND_HEADER;
                    rec.method       = {hdr_sr_reg[19], hdr_sr_reg[20]};
                    rec.packed_size  = {hdr_sr_reg[7], hdr_sr_reg[8],
                                        hdr_sr_reg[9], hdr_sr_reg[10]};
                    rec.plain_size   = {hdr_sr_reg[3], hdr_sr_reg[4],
                                        hdr_sr_reg[5], hdr_sr_reg[6]};
                    rec.name_length  = {hdr_sr_reg[1], hdr_sr_reg[2]};
                    rec.extra_length = {s_tdata, hdr_sr_reg[0]};
                    name_left_next   = rec.name_length;
                    skip_left_next   = {17'b0, rec.extra_length} + {1'b0, rec.packed_size};
                    idx_next         = '0;
                    if (rec.name_length != 16'd0) begin
                        phase_next = PH_NAME;
                    end else if (skip_left_next != 33'd0) begin
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_SEARCH;
                        win_next   = '0;
                    end
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            PH_NAME: begin
                rec_valid      = 1'b1;
                rec.kind       = KIND_NAME;
                rec.name_byte  = s_tdata;
                rec.last       = name_left_reg <= 16'd1;
                name_left_next = name_left_reg - 16'd1;
                if (name_left_next == 16'd0) begin
                    if (skip_left_reg != 33'd0) begin
                        phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_SEARCH;
                        win_next   = '0;
                    end
                end
            end
            PH_SKIP: begin
                if (skip_left_reg != 33'd0) begin
                    skip_left_next = skip_left_reg - 33'd1;
                end
                if (skip_left_next == 33'd0) begin
                    phase_next = PH_SEARCH;
                    win_next   = '0;
                end
            end
            default: begin
                phase_next = PH_SEARCH;
                if (win_reg == {SIG_B0, SIG_B1, SIG_B2} && s_tdata == SIG_B3) begin
                    win_next   = '0;
                    phase_next = PH_HEADER;
                    idx_next   = HDR_FIRST_IDX;
                end else begin
                    win_next = {win_reg[15:0], s_tdata};
                end
            end
        endcase
        if (phase_next == PH_HEADER) begin
            stat.status = ST_TRUNC_HDR;
        end else if (phase_next == PH_NAME && name_left_next != 16'd0) begin
            stat.status = ST_TRUNC_NAME;
        end else if (phase_next == PH_SKIP && skip_left_next != 33'd0) begin
            stat.status = ST_TRUNC_SKIP;
        end else begin
            stat.status = ST_CLEAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SEARCH;
            win_reg       <= '0;
            idx_reg       <= '0;
            name_left_reg <= '0;
            skip_left_reg <= '0;
        end else if (s_fire) begin
            if (s_tlast) begin
                phase_reg     <= PH_SEARCH;
                win_reg       <= '0;
                idx_reg       <= '0;
                name_left_reg <= '0;
                skip_left_reg <= '0;
            end else begin
                phase_reg     <= phase_next;
                win_reg       <= win_next;
                idx_reg       <= idx_next;
                name_left_reg <= name_left_next;
                skip_left_reg <= skip_left_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && phase_reg == PH_HEADER) begin
            hdr_sr_reg[0] <= s_tdata;
            for (int k = 1; k < HDR_SR_DEPTH; k++) begin
                hdr_sr_reg[k] <= hdr_sr_reg[k-1];
            end
        end
    end

    assign push_n   = s_fire ? ({1'b0, rec_valid} + {1'b0, s_tlast}) : 2'd0;
    assign slot_a   = rec_valid ? rec : stat;
    assign cnt_next = cnt_reg + CNT_W'(push_n) - CNT_W'(m_fire);

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            fifo_mem[wr_ptr_reg] <= slot_a;
        end
        if (push_n == 2'd2) begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= stat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(m_fire);
            cnt_reg    <= cnt_next;
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;
    assign m_tdata  = {6'b0, head.status, head.name_byte, head.extra_length,
                       head.name_length, head.plain_size, head.packed_size, head.method};

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_name_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_NAME |-> name_left_reg != 16'd0)
        else $error("name phase with no name bytes due");

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_left_reg != 33'd0)
        else $error("skip phase with nothing to skip");

    a_hdr_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> idx_reg >= HDR_FIRST_IDX && idx_reg <= HDR_LAST_IDX)
        else $error("header index out of range");

    a_eos_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tlast |=> phase_reg == PH_SEARCH && win_reg == 24'd0 && idx_reg == 5'd0)
        else $error("scanner not back to search after final beat");
`endif

endmodule
